>>> hw/rtl/ssal_pkg.sv
package ssal_pkg;

  localparam int unsigned MaxLen     = 4096;
  localparam int unsigned MaxLogRate = 6;
  localparam int unsigned AddrW      = 12;
  localparam int unsigned LenW       = 13;
  localparam int unsigned StepW      = 7;
  localparam int unsigned NumW       = AddrW + MaxLogRate;
  localparam int unsigned MetaW      = LenW + 1;

  localparam logic [1:0] ActLoadSa = 2'd0;
  localparam logic [1:0] ActLoadNp = 2'd1;
  localparam logic [1:0] ActQuery  = 2'd2;

  localparam logic [1:0] StatOk       = 2'd0;
  localparam logic [1:0] StatLongWalk = 2'd1;
  localparam logic [1:0] StatRange    = 2'd2;

  localparam logic CfgLogRate    = 1'b0;
  localparam logic CfgTextLength = 1'b1;

  typedef struct packed {
    logic [1:0]  action;
    logic [11:0] index;
    logic [11:0] value;
  } in_item_t;

  typedef struct packed {
    logic [11:0] position;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [NumW-1:0]  num;
    logic [StepW-1:0] sub;
    logic [LenW-1:0]  len;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [AddrW-1:0] rem;
  } mod_rsp_t;

endpackage

>>> hw/rtl/ssal_ram.sv
module ssal_ram #(
  parameter int unsigned Width = 12,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/ssal_modulo.sv
module ssal_modulo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ssal_pkg::mod_req_t req_i,
  output ssal_pkg::mod_rsp_t rsp_o
);
  import ssal_pkg::*;

  logic             run_q, run_d;
  logic [4:0]       cnt_q, cnt_d;
  logic [StepW-1:0] dec_q, dec_d;
  logic [NumW-1:0]  num_q, num_d;
  logic [AddrW-1:0] rem_q, rem_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [LenW-1:0]  trial;

  assign trial = {rem_q, num_q[NumW-1]};

  always_comb begin
    run_d = run_q;
    cnt_d = cnt_q;
    dec_d = dec_q;
    num_d = num_q;
    rem_d = rem_q;
    len_d = len_q;
    if (req_i.start) begin
      run_d = 1'b1;
      cnt_d = 5'(NumW);
      dec_d = req_i.sub;
      num_d = req_i.num;
      rem_d = '0;
      len_d = req_i.len;
    end else if (run_q) begin
      if (cnt_q != 5'd0) begin
        rem_d = (trial >= len_q) ? AddrW'(trial - len_q) : AddrW'(trial);
        num_d = {num_q[NumW-2:0], 1'b0};
        cnt_d = cnt_q - 5'd1;
      end else if (dec_q != '0) begin
        rem_d = (rem_q == '0) ? AddrW'(len_q - 13'd1) : rem_q - 12'd1;
        dec_d = dec_q - 7'd1;
      end else begin
        run_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
      dec_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
      dec_q <= dec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    len_q <= len_d;
  end

  assign rsp_o.done = run_q && (cnt_q == 5'd0) && (dec_q == '0);
  assign rsp_o.rem  = rem_q;

  // The partial remainder always stays below the divisor.
  a_rem_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_q && len_q != '0) |-> ({1'b0, rem_q} < len_q))
    else $error("remainder not below length");

  a_done_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.done && !req_i.start) |=> !run_q)
    else $error("unit kept running after done");

  a_dec_after_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_q && dec_q != $past(dec_q) && !$past(req_i.start)) |-> (cnt_q == 5'd0))
    else $error("decrement before division finished");

endmodule

>>> hw/rtl/sampled_suffix_array_lookup.sv
// Sampled suffix array lookup. Suffix array values (action 0) and next-position
// links (action 1) are each taken while the unit is idle. A query (action 2)
// walks the links, each step reading the mark and link memories (StWalkRd) and
// checking them (StWalkEv), for at most rate steps. It then reads the sample
// slot and reduces the result modulo the text length in a remainder unit that
// divides bit by bit and then steps back once per walk step. No input
// transaction is taken while a query runs; one finished result may wait in the
// output register while the next transaction is accepted.
module sampled_suffix_array_lookup (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [12:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ssal_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ssal_pkg::out_item_t out_data_o
);
  import ssal_pkg::*;

  typedef enum logic [5:0] {
    StIdle   = 6'b000001,
    StWalkRd = 6'b000010,
    StWalkEv = 6'b000100,
    StSlotRd = 6'b001000,
    StModRun = 6'b010000,
    StDone   = 6'b100000
  } state_e;

  state_e           state_q, state_d;
  logic [2:0]       log_rate_q;
  logic [LenW-1:0]  text_length_q;
  logic [LenW-1:0]  lc_q, lc_d;
  logic [LenW-1:0]  sc_q, sc_d;
  logic [AddrW-1:0] cur_q, cur_d;
  logic [StepW-1:0] v_q, v_d;
  logic [AddrW-1:0] pos_q, pos_d;
  logic [1:0]       stat_q, stat_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;

  logic [2:0]       lr_eff;
  logic [LenW-1:0]  len_eff;
  logic [StepW-1:0] rate;
  logic             accept;
  logic             is_mark;
  logic             load_ok;
  logic [LenW-1:0]  rank_new;
  logic             meta_we, np_we, sv_we;
  logic             walk_re, slot_re;
  logic [MetaW-1:0] meta_rd;
  logic [AddrW-1:0] np_rd;
  logic [AddrW-1:0] sv_rd;
  logic [AddrW-1:0] slot_addr;
  logic             marked;
  logic             out_free;
  mod_req_t         mreq;
  mod_rsp_t         mrsp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log_rate_q    <= 3'd5;
      text_length_q <= 13'd4096;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgLogRate:    log_rate_q    <= cfg_wdata_i[2:0];
        CfgTextLength: text_length_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign lr_eff  = (log_rate_q > 3'(MaxLogRate)) ? 3'(MaxLogRate) : log_rate_q;
  assign len_eff = (text_length_q == '0) ? 13'd1 :
                   (text_length_q > 13'(MaxLen)) ? 13'(MaxLen) : text_length_q;
  assign rate    = 7'd1 << lr_eff;

  assign accept   = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != StIdle);
  assign is_mark  = (in_data_i.value & 12'(rate - 7'd1)) == 12'd0;
  assign load_ok  = (lc_q < len_eff);
  assign rank_new = sc_q + {12'd0, is_mark};
  assign meta_we  = accept && (in_data_i.action == ActLoadSa) && load_ok;
  assign sv_we    = meta_we && is_mark;
  assign np_we    = accept && (in_data_i.action == ActLoadNp);
  assign walk_re  = (state_q == StWalkRd);
  assign slot_re  = (state_q == StWalkEv);
  assign slot_addr = AddrW'(meta_rd[LenW-1:0] - 13'd1);
  assign marked   = meta_rd[MetaW-1] && ({1'b0, cur_q} < lc_q);
  assign out_free = !out_valid_q || !out_stall_i;

  ssal_ram #(.Width(MetaW), .Depth(MaxLen)) u_meta (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (AddrW'(lc_q)),
    .wdata_i ({is_mark, rank_new}),
    .re_i    (walk_re),
    .raddr_i (cur_q),
    .rdata_o (meta_rd)
  );

  ssal_ram #(.Width(AddrW), .Depth(MaxLen)) u_next (
    .clk_i   (clk_i),
    .we_i    (np_we),
    .waddr_i (in_data_i.index),
    .wdata_i (in_data_i.value),
    .re_i    (walk_re),
    .raddr_i (cur_q),
    .rdata_o (np_rd)
  );

  ssal_ram #(.Width(AddrW), .Depth(MaxLen)) u_samp (
    .clk_i   (clk_i),
    .we_i    (sv_we),
    .waddr_i (AddrW'(sc_q)),
    .wdata_i (in_data_i.value >> lr_eff),
    .re_i    (slot_re),
    .raddr_i (slot_addr),
    .rdata_o (sv_rd)
  );

  always_comb begin
    mreq.start = (state_q == StSlotRd);
    mreq.num   = {{(NumW-AddrW){1'b0}}, sv_rd} << lr_eff;
    mreq.sub   = v_q;
    mreq.len   = len_eff;
  end

  ssal_modulo u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .rsp_o  (mrsp)
  );

  always_comb begin
    state_d     = state_q;
    lc_d        = lc_q;
    sc_d        = sc_q;
    cur_d       = cur_q;
    v_d         = v_q;
    pos_d       = pos_q;
    stat_d      = stat_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    unique case (state_q)
      StIdle: begin
        if (meta_we) begin
          lc_d = lc_q + 13'd1;
          sc_d = rank_new;
        end
        if (accept && in_data_i.action == ActQuery) begin
          cur_d  = in_data_i.index;
          v_d    = '0;
          pos_d  = '0;
          if ({1'b0, in_data_i.index} >= len_eff) begin
            stat_d  = StatRange;
            state_d = StDone;
          end else begin
            stat_d  = StatOk;
            state_d = StWalkRd;
          end
        end
      end
      StWalkRd: state_d = StWalkEv;
      StWalkEv: begin
        if (marked) begin
          state_d = StSlotRd;
        end else if (v_q >= rate) begin
          stat_d  = StatLongWalk;
          state_d = StDone;
        end else begin
          cur_d = np_rd;
          v_d   = v_q + 7'd1;
          if ({1'b0, np_rd} >= len_eff) begin
            stat_d  = StatRange;
            state_d = StDone;
          end else begin
            state_d = StWalkRd;
          end
        end
      end
      StSlotRd: state_d = StModRun;
      StModRun: begin
        if (mrsp.done) begin
          pos_d   = mrsp.rem;
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_free) begin
          out_valid_d    = 1'b1;
          out_d.position = pos_q;
          out_d.status   = stat_q;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      lc_q        <= '0;
      sc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lc_q        <= lc_d;
      sc_q        <= sc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    v_q    <= v_d;
    pos_q  <= pos_d;
    stat_q <= stat_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_samples_le_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sc_q <= lc_q)
    else $error("more samples than loaded values");

  a_walk_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWalkEv) |-> (v_q <= rate))
    else $error("walk went past the sampling rate");

  a_done_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone && out_free) |=> (out_valid_q && state_q == StIdle))
    else $error("finished query not delivered");

  a_error_zero_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone && stat_q != StatOk) |-> (pos_q == '0))
    else $error("nonzero position on error status");

endmodule

>>> bench/tb_sampled_suffix_array_lookup.sv
`timescale 1ns / 1ps

module tb_sampled_suffix_array_lookup;
  import ssal_pkg::*;

  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned SettleCycles = 260;
  localparam int unsigned HoldCycles = 400;
  localparam logic [1:0] ActIgnored = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_idx = 1'b0;
  logic [12:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;

  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;
  bit          failed = 1'b0;
  int unsigned cycles = 0;

  out_item_t   pending_lookups[$];

  bit          mark_q[MaxLen];
  logic [11:0] sample_q[MaxLen];
  logic [11:0] link_q[MaxLen];
  bit          link_set[MaxLen];
  int unsigned sa_loaded = 0;
  int unsigned samples_taken = 0;
  int unsigned log_rate_cfg = 5;
  int unsigned length_cfg = 4096;

  sampled_suffix_array_lookup u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int unsigned eff_log_rate();
    return (log_rate_cfg > MaxLogRate) ? MaxLogRate : log_rate_cfg;
  endfunction

  function automatic int unsigned eff_length();
    if (length_cfg == 0) return 1;
    if (length_cfg > MaxLen) return MaxLen;
    return length_cfg;
  endfunction

  // Follows the links from start; safe is cleared if an unwritten link would be read.
  function automatic void walk_links(input int unsigned start, output int unsigned cur,
                                     output int unsigned steps, output logic [1:0] st,
                                     output bit safe);
    int unsigned rate;
    int unsigned len;
    rate = 1 << eff_log_rate();
    len = eff_length();
    cur = start;
    steps = 0;
    st = StatOk;
    safe = 1'b1;
    if (cur >= len) begin
      st = StatRange;
    end else begin
      while (!mark_q[cur]) begin
        if (steps >= rate) begin
          st = StatLongWalk;
          break;
        end
        if (!link_set[cur]) begin
          safe = 1'b0;
          break;
        end
        cur = link_q[cur];
        steps++;
        if (cur >= len) begin
          st = StatRange;
          break;
        end
      end
    end
  endfunction

  function automatic bit lookup_safe(input int unsigned start);
    int unsigned cur;
    int unsigned steps;
    logic [1:0] st;
    bit safe;
    walk_links(start, cur, steps, st, safe);
    return safe;
  endfunction

  function automatic out_item_t lookup_position(input int unsigned start);
    int unsigned cur;
    int unsigned steps;
    int unsigned rank;
    logic [1:0] st;
    bit safe;
    longint x;
    longint m;
    out_item_t res;
    walk_links(start, cur, steps, st, safe);
    res.status = st;
    res.position = '0;
    if (st == StatOk) begin
      rank = 0;
      for (int unsigned k = 0; k <= cur; k++) rank += mark_q[k];
      x = longint'(1 << eff_log_rate()) * longint'(sample_q[rank - 1]) - longint'(steps);
      m = x % longint'(eff_length());
      if (m < 0) m += eff_length();
      res.position = m[11:0];
    end
    return res;
  endfunction

  function automatic void apply_item(input in_item_t it);
    int unsigned lr;
    lr = eff_log_rate();
    case (it.action)
      ActLoadSa: begin
        if (sa_loaded < eff_length()) begin
          if ((it.value & ((1 << lr) - 1)) == 0) begin
            mark_q[sa_loaded] = 1'b1;
            if (samples_taken < MaxLen) sample_q[samples_taken] = it.value >> lr;
            samples_taken++;
          end
          sa_loaded++;
        end
      end
      ActLoadNp: begin
        link_q[it.index] = it.value;
        link_set[it.index] = 1'b1;
      end
      ActQuery: pending_lookups.push_back(lookup_position(it.index));
      default: ;
    endcase
  endfunction

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_lookups.size() == 0) begin
        $error("unexpected result: position %0d status %0d", out_data.position,
               out_data.status);
        failed = 1'b1;
      end else begin
        want = pending_lookups.pop_front();
        if (out_data.position !== want.position) begin
          $error("position: expected %0d, actual %0d", want.position, out_data.position);
          failed = 1'b1;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_data.status);
          failed = 1'b1;
        end
      end
    end
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= idle_on && ($urandom_range(99) < 34);
    end
  end

  task automatic send_item(input in_item_t it);
    int unsigned gap;
    if (idle_on && $urandom_range(99) < 34) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk_i); while (in_stall);
    apply_item(it);
  endtask

  task automatic send_fields(input logic [1:0] act, input int unsigned idx,
                             input int unsigned val);
    in_item_t it;
    it.action = act;
    it.index = idx[11:0];
    it.value = val[11:0];
    send_item(it);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input int unsigned data);
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data[12:0];
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CfgLogRate) log_rate_cfg = data & 7;
    else length_cfg = data & 13'h1FFF;
  endtask

  function automatic int unsigned sa_value();
    int unsigned lr;
    lr = eff_log_rate();
    if ($urandom_range(1)) return $urandom_range(4095) & ~((1 << lr) - 1);
    return $urandom_range(4095);
  endfunction

  task automatic send_safe_query();
    int unsigned idx;
    for (int t = 0; t < 10; t++) begin
      idx = ($urandom_range(9) == 0) ? $urandom_range(4095)
                                      : $urandom_range(eff_length() - 1);
      if (lookup_safe(idx)) begin
        send_fields(ActQuery, idx, $urandom_range(4095));
        return;
      end
    end
    if (eff_length() < MaxLen) send_fields(ActQuery, 4095, $urandom_range(4095));
  endtask

  // Grows the text to new_len and fills the new links, mostly pointing inside.
  task automatic grow_text(input int unsigned new_len);
    int unsigned first;
    first = sa_loaded;
    write_reg(CfgTextLength, new_len);
    while (sa_loaded < eff_length()) send_fields(ActLoadSa, $urandom_range(4095), sa_value());
    for (int unsigned i = first; i < eff_length(); i++) begin
      if (!link_set[i]) begin
        send_fields(ActLoadNp, i, ($urandom_range(9) == 0) ? $urandom_range(4095)
                                                            : $urandom_range(eff_length() - 1));
      end
    end
  endtask

  task automatic run_mix(input int n);
    int unsigned pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 70) send_safe_query();
      else if (pick < 80) send_fields(ActLoadNp, $urandom_range(4095), $urandom_range(4095));
      else if (pick < 90) send_fields(ActLoadSa, $urandom_range(4095), $urandom_range(4095));
      else send_fields(ActIgnored, $urandom_range(4095), $urandom_range(4095));
    end
  endtask

  task automatic test_directed();
    write_reg(CfgLogRate, 2);
    write_reg(CfgTextLength, 16);
    send_fields(ActLoadSa, 0, 0);
    send_fields(ActLoadSa, 0, 4095);
    send_fields(ActLoadSa, 4095, 4092);
    while (sa_loaded < 16) send_fields(ActLoadSa, $urandom_range(4095), sa_value());
    send_fields(ActLoadSa, 0, 4092);
    for (int unsigned i = 0; i < 16; i++) send_fields(ActLoadNp, i, $urandom_range(15));
    send_fields(ActLoadNp, 1, 4095);
    send_fields(ActLoadNp, 4095, 4095);
    send_fields(ActIgnored, 4095, 4095);
    send_fields(ActQuery, 4095, 0);
    send_fields(ActQuery, 16, 0);
    send_fields(ActQuery, 0, 0);
    send_fields(ActQuery, 1, 0);
    send_fields(ActQuery, 2, 0);
    send_fields(ActQuery, 15, 0);
  endtask

  task automatic test_random_phases(input int phases);
    for (int p = 0; p < phases; p++) begin
      write_reg(CfgLogRate, ($urandom_range(1023) << 3) | $urandom_range(7));
      grow_text((sa_loaded + $urandom_range(4, 20) > 900) ? 900
                                                           : sa_loaded + $urandom_range(4, 20));
      run_mix(20);
    end
  endtask

  task automatic test_length_extremes();
    write_reg(CfgTextLength, 0);
    send_fields(ActQuery, 0, 0);
    send_fields(ActQuery, 1, 0);
    write_reg(CfgLogRate, 7);
    write_reg(CfgTextLength, 8191);
    run_mix(20);
    write_reg(CfgLogRate, 0);
    write_reg(CfgTextLength, 4096);
    run_mix(20);
    write_reg(CfgLogRate, 6);
    write_reg(CfgTextLength, 900);
    run_mix(30);
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int k = 0; k < 8; k++) send_safe_query();
    wait_drained();
    run_mix(10);
  endtask

  task automatic test_no_idling();
    idle_on = 1'b0;
    write_reg(CfgLogRate, 3);
    run_mix(40);
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_phases(8);
    test_backpressure();
    test_no_idling();
    test_length_extremes();
    test_random_phases(2);
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (!failed && pending_lookups.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sampled_suffix_array_lookup.f
hw/rtl/ssal_pkg.sv
hw/rtl/ssal_ram.sv
hw/rtl/ssal_modulo.sv
hw/rtl/sampled_suffix_array_lookup.sv
bench/tb_sampled_suffix_array_lookup.sv
